[hdl/hrlp_pkg.sv]
// Package for the HTTP request line parser: parse phases, status and method codes,
// character constants and the result record shared by the parser modules.
// Depends on nothing.
package hrlp_pkg;

  // Characters the parser recognizes.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_P      = 8'h50;

  // Packed letters of the known methods, newest letter in the low byte.
  localparam logic [31:0] LETTERS_GET  = 32'h0047_4554;
  localparam logic [31:0] LETTERS_HEAD = 32'h4845_4144;
  localparam logic [31:0] LETTERS_POST = 32'h504F_5354;

  // Width of the offsets carried in a result.
  localparam int unsigned RES_OFS_W = 12;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_METHOD  = 4'd1,
    PH_SP_URI  = 4'd2,
    PH_URI     = 4'd3,
    PH_SP_VER  = 4'd4,
    PH_H       = 4'd5,
    PH_HT      = 4'd6,
    PH_HTT     = 4'd7,
    PH_HTTP    = 4'd8,
    PH_MAJ1    = 4'd9,
    PH_MAJ2    = 4'd10,
    PH_DOT     = 4'd11,
    PH_MIN1    = 4'd12,
    PH_MIN2    = 4'd13,
    PH_SP_END  = 4'd14,
    PH_ALMOST  = 4'd15
  } phase_t;

  typedef enum logic [1:0] {
    ST_AGAIN      = 2'd0,
    ST_DONE       = 2'd1,
    ST_BAD_METHOD = 2'd2,
    ST_BAD_REQ    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MC_UNKNOWN = 2'd0,
    MC_GET     = 2'd1,
    MC_HEAD    = 2'd2,
    MC_POST    = 2'd3
  } method_t;

  // One result record, as produced for each input byte.
  typedef struct packed {
    status_t                status;
    method_t                method_code;
    logic [6:0]             version_major;
    logic [6:0]             version_minor;
    logic                   has_args;
    logic [RES_OFS_W-1:0]   uri_begin;
    logic [RES_OFS_W-1:0]   uri_last;
    logic [RES_OFS_W-1:0]   args_begin;
    logic [RES_OFS_W-1:0]   line_end;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

endpackage

[hdl/hrlp_byte_if.sv]
// Byte channel of the HTTP request line parser: valid/ready handshake and one byte.
// Depends on nothing.
interface hrlp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

[hdl/hrlp_result_if.sv]
// Result channel of the HTTP request line parser: valid/ready handshake and the
// parse status with the request line fields. Depends on nothing.
interface hrlp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  method_code;
  logic [6:0]  version_major;
  logic [6:0]  version_minor;
  logic        has_args;
  logic [11:0] uri_begin;
  logic [11:0] uri_last;
  logic [11:0] args_begin;
  logic [11:0] line_end;

  modport source (output valid, output status, output method_code, output version_major,
                  output version_minor, output has_args, output uri_begin, output uri_last,
                  output args_begin, output line_end, input ready);
  modport sink   (input valid, input status, input method_code, input version_major,
                  input version_minor, input has_args, input uri_begin, input uri_last,
                  input args_begin, input line_end, output ready);
endinterface

[hdl/hrlp_step.sv]
// Parser state and the step logic that consumes one byte and forms
// its result record. Depends on hrlp_pkg.
module hrlp_step #(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  logic [7:0]       in_byte,
  output hrlp_pkg::result_t res
);

  localparam int unsigned OFS_W = $clog2(MAX_LINE);
  localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(MAX_LINE - 1);

  hrlp_pkg::phase_t  phase;
  hrlp_pkg::phase_t  phase_next;
  hrlp_pkg::status_t status;
  hrlp_pkg::method_t method_kind;
  hrlp_pkg::method_t method_class;
  logic [OFS_W-1:0]  byte_offset;
  logic [OFS_W-1:0]  offset_inc;
  logic [OFS_W-1:0]  offset_dec;
  logic [31:0]       method_letters;
  logic [2:0]        method_length;
  logic [6:0]        major_value;
  logic [6:0]        minor_value;
  logic              args_seen;
  logic [OFS_W-1:0]  uri_first_pos;
  logic [OFS_W-1:0]  uri_last_pos;
  logic [OFS_W-1:0]  args_first_pos;
  logic [6:0]        digit;
  logic              c_upper;
  logic              c_digit;

  assign c_upper = hrlp_pkg::is_upper(in_byte);
  assign c_digit = hrlp_pkg::is_digit(in_byte);
  assign digit   = {3'b000, in_byte[3:0]};

  // Saturating offset of the following byte, and the offset of the previous byte.
  assign offset_inc = (byte_offset < OFS_LAST) ? byte_offset + 1'b1 : byte_offset;
  assign offset_dec = (byte_offset != '0) ? byte_offset - 1'b1 : '0;

  // Method class from the letters gathered so far.
  always_comb begin
    method_class = hrlp_pkg::MC_UNKNOWN;
    if (method_length == 3'd3 && method_letters == hrlp_pkg::LETTERS_GET) begin
      method_class = hrlp_pkg::MC_GET;
    end else if (method_length == 3'd4 && method_letters == hrlp_pkg::LETTERS_HEAD) begin
      method_class = hrlp_pkg::MC_HEAD;
    end else if (method_length == 3'd4 && method_letters == hrlp_pkg::LETTERS_POST) begin
      method_class = hrlp_pkg::MC_POST;
    end
  end

  // Status of the current byte in the current phase.
  always_comb begin
    status = hrlp_pkg::ST_AGAIN;
    unique case (phase)
      hrlp_pkg::PH_START: begin
        if (in_byte != hrlp_pkg::CH_CR && in_byte != hrlp_pkg::CH_LF && !c_upper)
          status = hrlp_pkg::ST_BAD_METHOD;
      end
      hrlp_pkg::PH_METHOD: begin
        if (in_byte != hrlp_pkg::CH_SPACE && !c_upper) status = hrlp_pkg::ST_BAD_METHOD;
      end
      hrlp_pkg::PH_SP_URI: begin
        if (in_byte != hrlp_pkg::CH_SLASH && in_byte != hrlp_pkg::CH_SPACE)
          status = hrlp_pkg::ST_BAD_REQ;
      end
      hrlp_pkg::PH_URI: begin
        status = hrlp_pkg::ST_AGAIN;
      end
      hrlp_pkg::PH_SP_VER: begin
        if (in_byte != hrlp_pkg::CH_H && in_byte != hrlp_pkg::CH_SPACE)
          status = hrlp_pkg::ST_BAD_REQ;
      end
      hrlp_pkg::PH_H, hrlp_pkg::PH_HT: begin
        if (in_byte != hrlp_pkg::CH_T) status = hrlp_pkg::ST_BAD_REQ;
      end
      hrlp_pkg::PH_HTT: begin
        if (in_byte != hrlp_pkg::CH_P) status = hrlp_pkg::ST_BAD_REQ;
      end
      hrlp_pkg::PH_HTTP: begin
        if (in_byte != hrlp_pkg::CH_SLASH) status = hrlp_pkg::ST_BAD_REQ;
      end
      hrlp_pkg::PH_MAJ1, hrlp_pkg::PH_MIN1: begin
        if (!c_digit) status = hrlp_pkg::ST_BAD_REQ;
      end
      hrlp_pkg::PH_MAJ2: begin
        if (in_byte != hrlp_pkg::CH_DOT && !c_digit) status = hrlp_pkg::ST_BAD_REQ;
      end
      hrlp_pkg::PH_DOT: begin
        if (in_byte != hrlp_pkg::CH_DOT) status = hrlp_pkg::ST_BAD_REQ;
      end
      hrlp_pkg::PH_MIN2: begin
        if (in_byte == hrlp_pkg::CH_LF) begin
          status = hrlp_pkg::ST_DONE;
        end else if (!c_digit && in_byte != hrlp_pkg::CH_SPACE && in_byte != hrlp_pkg::CH_CR) begin
          status = hrlp_pkg::ST_BAD_REQ;
        end
      end
      hrlp_pkg::PH_SP_END: begin
        if (in_byte == hrlp_pkg::CH_LF) begin
          status = hrlp_pkg::ST_DONE;
        end else if (in_byte != hrlp_pkg::CH_CR && in_byte != hrlp_pkg::CH_SPACE) begin
          status = hrlp_pkg::ST_BAD_REQ;
        end
      end
      hrlp_pkg::PH_ALMOST: begin
        status = (in_byte == hrlp_pkg::CH_LF) ? hrlp_pkg::ST_DONE : hrlp_pkg::ST_BAD_REQ;
      end
      default: status = hrlp_pkg::ST_BAD_REQ;
    endcase
  end

  // Next phase; a finished line or an error returns to the start phase.
  always_comb begin
    phase_next = phase;
    if (status != hrlp_pkg::ST_AGAIN) begin
      phase_next = hrlp_pkg::PH_START;
    end else begin
      unique case (phase)
        hrlp_pkg::PH_START:  if (c_upper) phase_next = hrlp_pkg::PH_METHOD;
        hrlp_pkg::PH_METHOD: if (in_byte == hrlp_pkg::CH_SPACE) phase_next = hrlp_pkg::PH_SP_URI;
        hrlp_pkg::PH_SP_URI: if (in_byte == hrlp_pkg::CH_SLASH) phase_next = hrlp_pkg::PH_URI;
        hrlp_pkg::PH_URI:    if (in_byte == hrlp_pkg::CH_SPACE) phase_next = hrlp_pkg::PH_SP_VER;
        hrlp_pkg::PH_SP_VER: if (in_byte == hrlp_pkg::CH_H) phase_next = hrlp_pkg::PH_H;
        hrlp_pkg::PH_H:      phase_next = hrlp_pkg::PH_HT;
        hrlp_pkg::PH_HT:     phase_next = hrlp_pkg::PH_HTT;
        hrlp_pkg::PH_HTT:    phase_next = hrlp_pkg::PH_HTTP;
        hrlp_pkg::PH_HTTP:   phase_next = hrlp_pkg::PH_MAJ1;
        hrlp_pkg::PH_MAJ1:   phase_next = hrlp_pkg::PH_MAJ2;
        hrlp_pkg::PH_MAJ2: begin
          phase_next = (in_byte == hrlp_pkg::CH_DOT) ? hrlp_pkg::PH_MIN1 : hrlp_pkg::PH_DOT;
        end
        hrlp_pkg::PH_DOT:    phase_next = hrlp_pkg::PH_MIN1;
        hrlp_pkg::PH_MIN1:   phase_next = hrlp_pkg::PH_MIN2;
        hrlp_pkg::PH_MIN2: begin
          phase_next = (in_byte == hrlp_pkg::CH_CR) ? hrlp_pkg::PH_ALMOST : hrlp_pkg::PH_SP_END;
        end
        hrlp_pkg::PH_SP_END: if (in_byte == hrlp_pkg::CH_CR) phase_next = hrlp_pkg::PH_ALMOST;
        hrlp_pkg::PH_ALMOST: phase_next = hrlp_pkg::PH_ALMOST;
        default:             phase_next = hrlp_pkg::PH_START;
      endcase
    end
  end

  // Result record; fields other than the status are only reported on a done line.
  always_comb begin
    res        = '0;
    res.status = status;
    if (status == hrlp_pkg::ST_DONE) begin
      res.method_code   = method_kind;
      res.version_major = major_value;
      res.version_minor = minor_value;
      res.has_args      = args_seen;
      res.uri_begin     = hrlp_pkg::RES_OFS_W'(uri_first_pos);
      res.uri_last      = hrlp_pkg::RES_OFS_W'(uri_last_pos);
      res.args_begin    = hrlp_pkg::RES_OFS_W'(args_first_pos);
      res.line_end      = hrlp_pkg::RES_OFS_W'(byte_offset);
    end
  end

  // Phase register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= hrlp_pkg::PH_START;
    end else if (step_en) begin
      phase <= phase_next;
    end
  end

  // Request state: offsets, method letters and version digits.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset    <= '0;
      method_letters <= '0;
      method_length  <= '0;
      method_kind    <= hrlp_pkg::MC_UNKNOWN;
      major_value    <= '0;
      minor_value    <= '0;
      args_seen      <= 1'b0;
      uri_first_pos  <= '0;
      uri_last_pos   <= '0;
      args_first_pos <= '0;
    end else if (step_en) begin
      if (status != hrlp_pkg::ST_AGAIN) begin
        byte_offset    <= '0;
        method_letters <= '0;
        method_length  <= '0;
        method_kind    <= hrlp_pkg::MC_UNKNOWN;
        major_value    <= '0;
        minor_value    <= '0;
        args_seen      <= 1'b0;
        uri_first_pos  <= '0;
        uri_last_pos   <= '0;
        args_first_pos <= '0;
      end else if (phase == hrlp_pkg::PH_START) begin
        // A first method letter opens a new request; line breaks are skipped.
        if (c_upper) begin
          byte_offset    <= OFS_W'(1);
          method_letters <= {24'h000000, in_byte};
          method_length  <= 3'd1;
          method_kind    <= hrlp_pkg::MC_UNKNOWN;
          major_value    <= '0;
          minor_value    <= '0;
          args_seen      <= 1'b0;
          uri_first_pos  <= '0;
          uri_last_pos   <= '0;
          args_first_pos <= '0;
        end
      end else begin
        byte_offset <= offset_inc;
        unique case (phase)
          hrlp_pkg::PH_METHOD: begin
            if (in_byte == hrlp_pkg::CH_SPACE) begin
              method_kind <= method_class;
            end else begin
              if (method_length < 3'd4) method_letters <= {method_letters[23:0], in_byte};
              if (method_length != 3'd7) method_length <= method_length + 3'd1;
            end
          end
          hrlp_pkg::PH_SP_URI: begin
            if (in_byte == hrlp_pkg::CH_SLASH) uri_first_pos <= byte_offset;
          end
          hrlp_pkg::PH_URI: begin
            if (in_byte == hrlp_pkg::CH_SPACE) begin
              uri_last_pos <= offset_dec;
            end else if (in_byte == hrlp_pkg::CH_QMARK) begin
              args_seen      <= 1'b1;
              args_first_pos <= offset_inc;
            end
          end
          hrlp_pkg::PH_MAJ1: major_value <= digit;
          hrlp_pkg::PH_MAJ2: begin
            if (c_digit) major_value <= 7'(major_value * 7'd10) + digit;
          end
          hrlp_pkg::PH_MIN1: minor_value <= digit;
          hrlp_pkg::PH_MIN2: begin
            if (c_digit) minor_value <= 7'(minor_value * 7'd10) + digit;
          end
          default: begin
            major_value <= major_value;
          end
        endcase
      end
    end
  end

`ifndef SYNTH
  // A done or error byte leaves the parser at the start of a fresh request.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    step_en && status != hrlp_pkg::ST_AGAIN |=> phase == hrlp_pkg::PH_START && byte_offset == '0)
    else $error("parser did not restart after a finished line or an error");

  // Between requests no offset is counted.
  a_start_offset: assert property (@(posedge clk) disable iff (rst)
    phase == hrlp_pkg::PH_START |-> byte_offset == '0)
    else $error("offset counted while waiting for a method");

  // The offset counter saturates at the line limit.
  a_offset_sat: assert property (@(posedge clk) disable iff (rst)
    byte_offset <= OFS_LAST)
    else $error("offset passed the line limit");

  // A line is only finished by a line feed.
  a_done_on_lf: assert property (@(posedge clk) disable iff (rst)
    step_en && status == hrlp_pkg::ST_DONE |-> in_byte == hrlp_pkg::CH_LF)
    else $error("line finished on a byte other than a line feed");
`endif

endmodule

[hdl/hrlp_out_reg.sv]
// Result register of the HTTP request line parser with its valid flag.
// Depends on hrlp_pkg.
module hrlp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hrlp_pkg::result_t din,
  input  logic              sink_ready,
  output logic              valid,
  output hrlp_pkg::result_t dout,
  output logic              load_ok
);

  // The register can take a new result when it is empty or being drained.
  assign load_ok = !valid || sink_ready;

  // Valid flag: set on a load, cleared once the held result is transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (sink_ready) begin
      valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

[hdl/http_request_line_parser.sv]
// Top level of the HTTP request line parser: input byte register, parse step and
// result register. Depends on hrlp_pkg, hrlp_byte_if, hrlp_result_if, hrlp_step, hrlp_out_reg.
//
// Usage:
//   line_byte carries the request line one byte per transfer; result returns exactly
//   one record per byte, in order. The status field says whether more bytes are needed,
//   the line is complete, or the method or request was malformed. The remaining fields
//   (method, version, URI and argument offsets, line end offset) are meaningful only on
//   a complete line and read zero otherwise. Offsets count from the first method letter
//   and saturate at MAX_LINE-1.
//   Path: a transferred byte is held in the input register, and its result is then
//   registered in the result register, from which it can be transferred out. Throughput:
//   one byte per cycle while result is taken; the parse state is updated as a byte
//   moves from the input register to the result register.
//   Reset (rst, synchronous): both registers empty, parser in its start phase with all
//   request state cleared.
//   Stall: while result is not taken the result register holds its record, the input
//   register keeps one more byte, and line_byte.ready drops until the result moves.
module http_request_line_parser #(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic          clk,
  input  logic          rst,
  hrlp_byte_if.sink     line_byte,
  hrlp_result_if.source result
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              load_ok;
  logic              step_en;
  hrlp_pkg::result_t step_res;
  hrlp_pkg::result_t out_res;

  // The byte register accepts when empty or when its byte moves on this cycle.
  assign step_en         = s1_valid && load_ok;
  assign line_byte.ready = !s1_valid || load_ok;

  // Input byte register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (line_byte.valid && line_byte.ready) begin
      s1_valid <= 1'b1;
    end else if (step_en) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_byte.valid && line_byte.ready) begin
      s1_byte <= line_byte.in_byte;
    end
  end

  hrlp_step #(
    .MAX_LINE (MAX_LINE)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .in_byte (s1_byte),
    .res     (step_res)
  );

  hrlp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (step_en),
    .din        (step_res),
    .sink_ready (result.ready),
    .valid      (result.valid),
    .dout       (out_res),
    .load_ok    (load_ok)
  );

  // Result channel payload.
  assign result.status        = out_res.status;
  assign result.method_code   = out_res.method_code;
  assign result.version_major = out_res.version_major;
  assign result.version_minor = out_res.version_minor;
  assign result.has_args      = out_res.has_args;
  assign result.uri_begin     = out_res.uri_begin;
  assign result.uri_last      = out_res.uri_last;
  assign result.args_begin    = out_res.args_begin;
  assign result.line_end      = out_res.line_end;

`ifndef SYNTH
  // A byte waiting in the input register is neither lost nor changed.
  a_byte_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !step_en |=> s1_valid && $stable(s1_byte))
    else $error("buffered input byte lost or changed while stalled");
`endif

endmodule
